FILE: design/tccw_pkg.sv
package tccw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int IDX_W   = 11;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int WORD_W  = CHAR_W + ATTR_W;
  localparam int PHASE_W = $clog2(TAB_STOP);
  localparam int CNT_W   = $clog2(TAB_STOP + 1);
  localparam int FULL_W  = COL_W + ROW_W;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h02;

  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

  // The phase is the column modulo the tab stop, kept alongside the column.
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [PHASE_W-1:0] phase;
  } cursor_t;

endpackage

FILE: design/tccw_cursor_unit.sv
module tccw_cursor_unit
  import tccw_pkg::*;
(
  input  cursor_t          cur,
  output logic [IDX_W-1:0] index,
  output cursor_t          advanced,
  output cursor_t          retreated,
  output logic [ROW_W-1:0] row_down
);

  logic [FULL_W-1:0]  full_index;
  logic [ROW_W:0]     row_inc;
  logic [COL_W:0]     col_inc;
  logic [PHASE_W:0]   phase_inc;

  assign full_index = FULL_W'(cur.row) * FULL_W'(COLUMNS) + FULL_W'(cur.col);
  assign index      = full_index[IDX_W-1:0];

  assign row_inc   = {1'b0, cur.row} + 1'b1;
  assign row_down  = (row_inc >= (ROW_W + 1)'(ROWS)) ? ROW_W'(1) : row_inc[ROW_W-1:0];

  assign col_inc   = {1'b0, cur.col} + 1'b1;
  assign phase_inc = {1'b0, cur.phase} + 1'b1;

  always_comb begin
    if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
      advanced.col   = '0;
      advanced.row   = row_down;
      advanced.phase = '0;
    end else begin
      advanced.col   = col_inc[COL_W-1:0];
      advanced.row   = cur.row;
      advanced.phase = (phase_inc == (PHASE_W + 1)'(TAB_STOP)) ? '0
                                                               : phase_inc[PHASE_W-1:0];
    end
  end

  always_comb begin
    retreated.col   = cur.col - 1'b1;
    retreated.row   = cur.row;
    retreated.phase = (cur.phase == '0) ? PHASE_W'(TAB_STOP - 1) : cur.phase - 1'b1;
  end

endmodule

FILE: design/tccw_seq.sv
module tccw_seq
  import tccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ATTR_W-1:0] attr,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_index,
  output logic [WORD_W-1:0] out_word,
  output logic              out_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state;
  cursor_t           cur;
  logic [CHAR_W-1:0] ch;
  logic              adv;
  logic              tab;
  logic [CNT_W-1:0]  count;

  logic [IDX_W-1:0]  index;
  cursor_t           advanced;
  cursor_t           retreated;
  logic [ROW_W-1:0]  row_down;
  logic [CNT_W-1:0]  count_next;
  logic              load;
  logic              done;

  tccw_cursor_unit u_cursor (
    .cur       (cur),
    .index     (index),
    .advanced  (advanced),
    .retreated (retreated),
    .row_down  (row_down)
  );

  assign in_ready   = (state == ST_IDLE);
  assign load       = (state == ST_EMIT) && (!out_valid || out_ready);
  assign count_next = count + 1'b1;
  assign done       = !tab || (advanced.phase == '0) || (count_next == CNT_W'(TAB_STOP));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= '0;
      out_valid <= 1'b0;
      adv       <= 1'b0;
      tab       <= 1'b0;
      count     <= '0;
    end else begin
      if (out_ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            count <= '0;
            case (in_char)
              CODE_LF: begin
                cur.col   <= '0;
                cur.row   <= row_down;
                cur.phase <= '0;
              end
              CODE_CR: begin
                cur.col   <= '0;
                cur.phase <= '0;
              end
              CODE_BS: begin
                if (cur.col != '0) begin
                  cur   <= retreated;
                  ch    <= CODE_SPACE;
                  adv   <= 1'b0;
                  tab   <= 1'b0;
                  state <= ST_EMIT;
                end
              end
              CODE_TAB: begin
                ch    <= CODE_SPACE;
                adv   <= 1'b1;
                tab   <= 1'b1;
                state <= ST_EMIT;
              end
              default: begin
                ch    <= in_char;
                adv   <= 1'b1;
                tab   <= 1'b0;
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (load) begin
            out_valid <= 1'b1;
            out_index <= index;
            out_word  <= {attr, ch};
            out_last  <= done;
            count     <= count_next;
            if (adv) begin
              cur <= advanced;
            end
            if (done) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/text_console_cursor_writer_top.sv
// Channel    Direction  Payload
// s_axis     in         tdata[7:0] char_code
// m_axis     out        tdata[10:0] cell_index, tdata[26:11] cell_word; tlast last_write
// cfg        in         cfg_wr_data[7:0] text_attribute
//
// A request is accepted in the idle state; the emit state then registers its cell writes
// in turn, one for a printable byte or a backspace that writes and up to eight for a tab.
// Line feed, carriage return and a backspace at column zero give no write and leave the
// sequencer idle. The sequencer drives one shared cursor unit, so the block takes no new
// request until the last write of the current one is registered.
// Reset clears the cursor and sets the attribute to 02h. A stalled output holds the
// write in its register and the sequencer waits.
module text_console_cursor_writer_top
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [10:0] cell_index, [26:11] cell_word, rest zero
  output logic        m_axis_tlast,   // last_write
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data     // [7:0] text_attribute
);

  logic [ATTR_W-1:0] attr;
  logic [IDX_W-1:0]  cell_index;
  logic [WORD_W-1:0] cell_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr <= cfg_wr_data;
    end
  end

  tccw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_char   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (cell_index),
    .out_word  (cell_word),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, cell_word, cell_index};

endmodule

FILE: dv/text_console_cursor_writer_top_tb.sv
`timescale 1ns / 1ps

module text_console_cursor_writer_top_tb
  import tccw_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int CFG_SETTLE  = 4;
  localparam int END_SETTLE  = 20;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_e;

  typedef struct packed {
    logic [IDX_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    logic              last;
  } cell_write_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_wr_en     = 1'b0;
  logic [7:0]  cfg_wr_data   = '0;

  logic [COL_W-1:0]  cur_col   = '0;
  logic [ROW_W-1:0]  cur_row   = '0;
  logic [ATTR_W-1:0] text_attr = ATTR_RESET;
  cell_write_t       pending_cells[$];
  int                mismatches  = 0;
  int                burst_left  = 0;
  bit                gaps_on     = 1'b0;
  rx_mode_e          rx_mode     = RX_OPEN;
  int                rx_hold     = 0;
  int                rx_tick     = 0;

  text_console_cursor_writer_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic logic [IDX_W-1:0] cursor_pos();
    int p;
    p = int'(cur_row) * COLUMNS + int'(cur_col);
    return p[IDX_W-1:0];
  endfunction

  function automatic void next_row();
    if (int'(cur_row) + 1 >= ROWS) begin
      cur_row = 1;
    end else begin
      cur_row = cur_row + 1'b1;
    end
  endfunction

  function automatic void step_cursor();
    if (int'(cur_col) + 1 >= COLUMNS) begin
      cur_col = '0;
      next_row();
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endfunction

  function automatic void track_char(input logic [7:0] ch);
    logic [IDX_W-1:0] pos;
    int               n;
    bit               done;
    n = 0;
    case (ch)
      CODE_LF: begin
        cur_col = '0;
        next_row();
      end
      CODE_CR: begin
        cur_col = '0;
      end
      CODE_BS: begin
        if (cur_col != 0) begin
          cur_col = cur_col - 1'b1;
          pending_cells.push_back('{cursor_pos(), {text_attr, CODE_SPACE}, 1'b1});
        end
      end
      CODE_TAB: begin
        do begin
          pos = cursor_pos();
          step_cursor();
          n++;
          done = (int'(cur_col) % TAB_STOP == 0) || (n >= TAB_STOP);
          pending_cells.push_back('{pos, {text_attr, CODE_SPACE}, done});
        end while (!done);
      end
      default: begin
        pos = cursor_pos();
        step_cursor();
        pending_cells.push_back('{pos, {text_attr, ch}, 1'b1});
      end
    endcase
  endfunction

  function automatic void note_mismatch(input cell_write_t want, input cell_write_t got,
                                        input bit unexpected);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected) begin
        $display("%0t: unexpected write pos %0d word %h last %0b",
                 $time, got.pos, got.word, got.last);
      end else begin
        $display("%0t: expected pos %0d word %h last %0b, got pos %0d word %h last %0b",
                 $time, want.pos, want.word, want.last, got.pos, got.word, got.last);
      end
    end
  endfunction

  // Writes are taken before requests, since a write never belongs to the request
  // accepted at the same edge.
  always @(posedge clk) begin
    cell_write_t got;
    cell_write_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[10:0], m_axis_tdata[26:11], m_axis_tlast};
        if (pending_cells.size() == 0) begin
          note_mismatch(got, got, 1'b1);
        end else begin
          want = pending_cells.pop_front();
          if (got.pos != want.pos || got.word != want.word || got.last != want.last) begin
            note_mismatch(want, got, 1'b0);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_char(s_axis_tdata);
      end
    end
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN: begin
        m_axis_tready <= 1'b1;
      end
      RX_RANDOM: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      RX_PERIODIC: begin
        m_axis_tready <= (rx_tick % 3 == 0);
      end
      default: begin
        if (rx_hold != 0) begin
          rx_hold <= rx_hold - 1;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          rx_hold <= $urandom_range(4, 12);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_char(input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_idle(input int settle);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_attribute(input logic [7:0] attr);
    wait_idle(CFG_SETTLE);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= attr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    text_attr = attr;
  endtask

  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return CODE_TAB;
    if (r < 25) return CODE_BS;
    if (r < 33) return CODE_LF;
    if (r < 38) return CODE_CR;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_reset_attribute();
    rx_mode = RX_OPEN;
    gaps_on = 1'b0;
    send_char(8'h41);
  endtask

  task automatic test_control_codes();
    rx_mode = RX_RANDOM;
    gaps_on = 1'b1;
    send_char(CODE_BS);
    send_char(CODE_BS);
    send_char(CODE_TAB);
    send_char(8'hFF);
    send_char(CODE_TAB);
    send_char(8'h00);
    send_char(CODE_CR);
    send_char(CODE_LF);
    send_char(8'h7F);
    send_char(8'h80);
  endtask

  task automatic test_attribute_extremes();
    set_attribute(8'hFF);
    send_char(8'h5A);
    set_attribute(8'h00);
    send_char(CODE_SPACE);
    send_char(CODE_TAB);
  endtask

  task automatic test_line_wrap();
    rx_mode = RX_LONG;
    gaps_on = 1'b0;
    send_char(CODE_CR);
    repeat (COLUMNS / TAB_STOP) send_char(CODE_TAB);
    send_char(8'h55);
  endtask

  task automatic test_row_wrap();
    rx_mode = RX_PERIODIC;
    gaps_on = 1'b1;
    repeat (40) send_char(($urandom_range(0, 9) < 7) ? CODE_LF : random_char());
  endtask

  task automatic test_random_text();
    for (int k = 0; k < 4; k++) begin
      set_attribute(k == 0 ? 8'hFF : k == 1 ? 8'h00 : 8'($urandom_range(0, 255)));
      rx_mode = rx_mode_e'(k);
      gaps_on = (k != 0);
      repeat (24) send_char(random_char());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_attribute();
    test_control_codes();
    test_attribute_extremes();
    test_line_wrap();
    test_row_wrap();
    test_random_text();
    wait_idle(END_SETTLE);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
